FILE: rtl/firs_pkg.sv
// shared widths, codes, control types and sequencer states of the fir filter
`default_nettype none

package firs_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEFF_W  = 16;
	localparam int INDEX_W  = 6;
	localparam int PROD_W   = SAMPLE_W + COEFF_W;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_FILTER = 1'b1;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_HOLD
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/firs_if.sv
// request channels of the fir filter: input items and filtered results
`default_nettype none

interface firs_in_if import firs_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic        [INDEX_W-1:0]  coeff_index;
	logic signed [COEFF_W-1:0]  coeff_value;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, func, coeff_index, coeff_value, sample_in, input ready);
	modport sink (input valid, func, coeff_index, coeff_value, sample_in, output ready);
endinterface

interface firs_out_if import firs_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] filtered_sample;
	logic                       clipped;

	modport source (output valid, filtered_sample, clipped, input ready);
	modport sink (input valid, filtered_sample, clipped, output ready);
endinterface

`default_nettype wire

FILE: rtl/fir_filter_saturating_unit.sv
// top level: sequencer over coefficient and circular sample memories feeding one mac
//
// channel  dir  payload                                        request when
// in_ch    in   func, coeff_index, coeff_value, sample_in      valid && ready
// out_ch   out  filtered_sample, clipped                       valid && ready
//
// a sample is filtered by the single mac stepping one tap per cycle
// through both memories
// reset clears the valid bits of both memories, so every entry reads as zero
// a new request is taken while a finished result still waits on out_ch
// a result that cannot leave holds the sequencer until out_ch frees up
`default_nettype none

module fir_filter_saturating_unit import firs_pkg::*; #(
	parameter int TAPS            = 60,
	parameter int COEFF_FRAC_BITS = 15
) (
	input  wire logic clk,
	input  wire logic arst_n,
	firs_in_if.sink   in_ch,
	firs_out_if.source out_ch
);

	localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);

	state_t state_q, state_d;

	logic [AW-1:0] cnt_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] dp_q;

	logic accept;
	logic is_load;
	logic coef_we;
	logic slot_free;
	logic out_load;
	logic run_last;

	mac_ctrl_t ctrl_s0, ctrl_s1;

	logic signed [COEFF_W-1:0]  coef_rd;
	logic signed [SAMPLE_W-1:0] samp_rd;
	logic signed [SAMPLE_W-1:0] mac_res;
	logic                       mac_clip;
	logic                       mac_done;

	logic                       out_vld_q;
	logic signed [SAMPLE_W-1:0] out_data_q;
	logic                       out_clip_q;

	assign accept    = in_ch.valid & in_ch.ready;
	assign is_load   = (in_ch.func == FUNC_LOAD);
	assign coef_we   = accept & is_load & (32'(in_ch.coeff_index) < TAPS);
	assign slot_free = ~out_vld_q | out_ch.ready;
	assign run_last  = (cnt_q == LAST_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		out_load    = 1'b0;
		ctrl_s0     = '0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (accept && (in_ch.func == FUNC_FILTER)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				ctrl_s0.vld   = 1'b1;
				ctrl_s0.first = (cnt_q == '0);
				ctrl_s0.last  = run_last;
				if (run_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (mac_done) begin
					if (slot_free) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// newest sample goes in at wp, taps walk backward from it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= '0;
			dp_q  <= '0;
		end else if (accept && !is_load) begin
			cnt_q <= '0;
			dp_q  <= wp_q;
			wp_q  <= (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
		end else if (state_q == ST_RUN) begin
			cnt_q <= cnt_q + 1'b1;
			dp_q  <= (dp_q == '0) ? LAST_ADDR : dp_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_s0;
		end
	end

	firs_ram #(
		.DEPTH (TAPS),
		.WIDTH (COEFF_W)
	) u_coef_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (coef_we),
		.waddr  (AW'(in_ch.coeff_index)),
		.wdata  (in_ch.coeff_value),
		.raddr  (cnt_q),
		.rdata  (coef_rd)
	);

	firs_ram #(
		.DEPTH (TAPS),
		.WIDTH (SAMPLE_W)
	) u_delay_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (accept & ~is_load),
		.waddr  (wp_q),
		.wdata  (in_ch.sample_in),
		.raddr  (dp_q),
		.rdata  (samp_rd)
	);

	firs_mac #(
		.TAPS (TAPS),
		.FRAC (COEFF_FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef_rd),
		.samp   (samp_rd),
		.ctrl   (ctrl_s1),
		.res    (mac_res),
		.clip   (mac_clip),
		.done   (mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= mac_res;
			out_clip_q <= mac_clip;
		end
	end

	assign out_ch.valid           = out_vld_q;
	assign out_ch.filtered_sample = out_data_q;
	assign out_ch.clipped         = out_clip_q;

endmodule

`default_nettype wire

FILE: rtl/firs_ram.sv
// single-port-write, registered-read memory with per-entry valid bits reading zero
`default_nettype none

module firs_ram #(
	parameter int DEPTH = 60,
	parameter int WIDTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// entries never written since reset read as zero
	always_ff @(posedge clk) begin
		rdata_q <= vld_q[raddr] ? mem[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/firs_mac.sv
// shared multiply-accumulate with scale, truncation toward zero and saturation
`default_nettype none

module firs_mac import firs_pkg::*; #(
	parameter int TAPS = 60,
	parameter int FRAC = 15
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic signed [COEFF_W-1:0]  coef,
	input  wire logic signed [SAMPLE_W-1:0] samp,
	input  wire mac_ctrl_t                  ctrl,
	output logic signed [SAMPLE_W-1:0]      res,
	output logic                            clip,
	output logic                            done
);

	localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int ACC_W = PROD_W + 1 + AW;
	localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'((64'sd1 <<< FRAC) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

	logic signed [PROD_W-1:0]   prod_s2;
	mac_ctrl_t                  ctrl_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       acc_done_q;
	logic signed [ACC_W-1:0]    biased;
	logic signed [ACC_W-1:0]    scaled;
	logic signed [SAMPLE_W-1:0] res_q;
	logic                       clip_q;
	logic                       done_q;

	always_ff @(posedge clk) begin
		prod_s2 <= coef * samp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2    <= '0;
			acc_done_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			ctrl_s2    <= ctrl;
			acc_done_q <= ctrl_s2.vld & ctrl_s2.last;
			done_q     <= acc_done_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s2.vld) begin
			acc_q <= ctrl_s2.first ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	// negative sums get a bias so the arithmetic shift truncates toward zero
	always_comb begin
		biased = acc_q + (acc_q[ACC_W-1] ? BIAS : '0);
		scaled = biased >>> FRAC;
	end

	always_ff @(posedge clk) begin
		if (acc_done_q) begin
			if (scaled > SAT_MAX) begin
				res_q  <= SAMPLE_W'(SAT_MAX);
				clip_q <= 1'b1;
			end else if (scaled < SAT_MIN) begin
				res_q  <= SAMPLE_W'(SAT_MIN);
				clip_q <= 1'b1;
			end else begin
				res_q  <= scaled[SAMPLE_W-1:0];
				clip_q <= 1'b0;
			end
		end
	end

	assign res  = res_q;
	assign clip = clip_q;
	assign done = done_q;

endmodule

`default_nettype wire
